/* rtl/sfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, register indexes and helpers for the stream find/replace core.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int MaxFindLengthDefault    = 8;
   localparam int MaxReplaceLengthDefault = 8;

   // flush never produces more than this many results for one item
   localparam int MaxResults = 8;
   // length registers are 4 bits, so a burst never exceeds 15 beats
   localparam int LenWidth   = 4;
   localparam int LenMax     = 15;
   localparam int BeatWidth  = 4;

   localparam logic [1:0] RegFindLength    = 2'd0;
   localparam logic [1:0] RegFindPattern   = 2'd1;
   localparam logic [1:0] RegReplaceLength = 2'd2;
   localparam logic [1:0] RegReplaceText   = 2'd3;

   typedef struct packed {
      logic [BeatWidth-1:0] beats;   // results caused by the item, 0 = none
      logic                 marker;  // single result without data
      logic                 done;    // burst closes the string
   } sfr_burst_type;

   // byte i of a packed 64-bit register, zero past the eighth byte
   function automatic logic [7:0] packed_byte(input logic [63:0] word, input int i);
      logic [63:0] shifted;
      shifted = (i < 8) ? (word >> (i * 8)) : 64'd0;
      return shifted[7:0];
   endfunction

endpackage

/* rtl/sfr_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_step
// Per-item window update: insert, compare, shift or clear, and the result
// burst that the item causes (replacement, oldest byte and/or flush).
// ----------------------------------------------------------------------------
module sfr_step #(
   parameter int MAX_FIND_LENGTH = sfr_pkg::MaxFindLengthDefault,
   parameter int BURST_DEPTH     = sfr_pkg::MaxResults,
   parameter int REPL_CAP        = sfr_pkg::MaxReplaceLengthDefault
) (
   input  logic [MAX_FIND_LENGTH-1:0][7:0]          window,
   input  logic [$clog2(MAX_FIND_LENGTH+1)-1:0]     fill,
   input  logic [sfr_pkg::LenWidth-1:0]             find_length,
   input  logic [63:0]                              find_pattern,
   input  logic [sfr_pkg::LenWidth-1:0]             replace_length,
   input  logic [63:0]                              replace_text,
   input  logic [7:0]                               data_byte,
   input  logic                                     byte_present,
   input  logic                                     end_of_string,
   output logic [MAX_FIND_LENGTH-1:0][7:0]          window_out,
   output logic [$clog2(MAX_FIND_LENGTH+1)-1:0]     fill_out,
   output logic [BURST_DEPTH-1:0][7:0]              burst_bytes,
   output sfr_pkg::sfr_burst_type                   burst
);
   import sfr_pkg::*;

   localparam int FillWidth = $clog2(MAX_FIND_LENGTH + 1);
   localparam int WideDepth = (MAX_FIND_LENGTH > BURST_DEPTH) ? MAX_FIND_LENGTH : BURST_DEPTH;

   logic [FillWidth-1:0]              flen;
   logic [BeatWidth-1:0]              rlen;
   logic [MAX_FIND_LENGTH-1:0][7:0]   win_next;
   logic [WideDepth-1:0][7:0]         win_wide;
   logic [FillWidth-1:0]              fill_ins;
   logic [FillWidth-1:0]              fill_after;
   logic [FillWidth:0]                flush_total;
   logic                              full;
   logic                              hit;

   always_comb begin
      // effective lengths
      if (find_length == '0) begin
         flen = FillWidth'(1);
      end else if (32'(find_length) > MAX_FIND_LENGTH) begin
         flen = FillWidth'(MAX_FIND_LENGTH);
      end else begin
         flen = FillWidth'(find_length);
      end
      if (32'(replace_length) > REPL_CAP) begin
         rlen = BeatWidth'(REPL_CAP);
      end else begin
         rlen = BeatWidth'(replace_length);
      end

      win_next = window;
      for (int i = 0; i < MAX_FIND_LENGTH; i++) begin
         if (byte_present && (fill == FillWidth'(i))) begin
            win_next[i] = data_byte;
         end
      end
      fill_ins = fill + FillWidth'(byte_present);
      full     = byte_present && (fill_ins >= flen);

      hit = full;
      for (int i = 0; i < MAX_FIND_LENGTH; i++) begin
         if ((FillWidth'(i) < flen) && (win_next[i] != packed_byte(find_pattern, i))) begin
            hit = 1'b0;
         end
      end

      if (hit) begin
         window_out = win_next;
         fill_after = '0;
      end else if (full) begin
         window_out = win_next >> 8;
         fill_after = fill_ins - FillWidth'(1);
      end else begin
         window_out = win_next;
         fill_after = fill_ins;
      end
      fill_out = end_of_string ? '0 : fill_after;

      // miss: oldest byte then flushed bytes are win_next[0..]; idle: flush only
      flush_total = (FillWidth + 1)'(full) +
                    (end_of_string ? {1'b0, fill_after} : '0);
      if (32'(flush_total) > MaxResults) begin
         flush_total = (FillWidth + 1)'(MaxResults);
      end

      burst.done   = end_of_string;
      burst.marker = 1'b0;
      if (hit) begin
         burst.beats = rlen;
      end else begin
         burst.beats = BeatWidth'(flush_total);
      end
      if (end_of_string && (burst.beats == '0)) begin
         burst.marker = 1'b1;
         burst.beats  = BeatWidth'(1);
      end

      win_wide = (WideDepth * 8)'(win_next);
      for (int j = 0; j < BURST_DEPTH; j++) begin
         burst_bytes[j] = hit ? packed_byte(replace_text, j) : win_wide[j];
      end
   end

endmodule

/* rtl/stream_find_replace_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Streaming find/replace: leftmost non-overlapping matches of the pattern are
// swapped for the replacement; end of string flushes pending bytes.
// ----------------------------------------------------------------------------
// Latency: first result of an item is presented the cycle after its transfer.
// Throughput: one item per cycle while each item causes at most one result
//   and the result side does not stall; an item causing several results holds
//   the result register until its last beat leaves, and the next item transfers together with that beat.
// Reset: lengths go to find 1 / replace 0, strings to zero, window emptied.
// ----------------------------------------------------------------------------
module stream_find_replace_core #(
   parameter int MAX_FIND_LENGTH    = sfr_pkg::MaxFindLengthDefault,
   parameter int MAX_REPLACE_LENGTH = sfr_pkg::MaxReplaceLengthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic        rsp_last_of_run,
   output logic        rsp_string_done
);
   import sfr_pkg::*;

   localparam int FillWidth  = $clog2(MAX_FIND_LENGTH + 1);
   localparam int ReplCap    = (MAX_REPLACE_LENGTH < LenMax) ? MAX_REPLACE_LENGTH : LenMax;
   localparam int BurstDepth = (ReplCap > MaxResults) ? ReplCap : MaxResults;
   localparam int IdxWidth   = $clog2(BurstDepth);

   logic [LenWidth-1:0]              find_length_ff, find_length_in;
   logic [63:0]                      find_pattern_ff, find_pattern_in;
   logic [LenWidth-1:0]              replace_length_ff, replace_length_in;
   logic [63:0]                      replace_text_ff, replace_text_in;
   logic [MAX_FIND_LENGTH-1:0][7:0]  window_ff, window_in;
   logic [FillWidth-1:0]             fill_ff, fill_in;
   logic [BurstDepth-1:0][7:0]       burst_ff, burst_in;
   sfr_burst_type                    burst_ctl_ff, burst_ctl_in;
   logic [IdxWidth-1:0]              idx_ff, idx_in;
   logic                             busy_ff, busy_in;

   logic [MAX_FIND_LENGTH-1:0][7:0]  step_window;
   logic [FillWidth-1:0]             step_fill;
   logic [BurstDepth-1:0][7:0]       step_bytes;
   sfr_burst_type                    step_burst;
   logic                             last_beat;
   logic                             rsp_xfer;
   logic                             req_xfer;

   sfr_step #(
      .MAX_FIND_LENGTH (MAX_FIND_LENGTH),
      .BURST_DEPTH     (BurstDepth),
      .REPL_CAP        (ReplCap)
   ) u_step (
      .window         (window_ff),
      .fill           (fill_ff),
      .find_length    (find_length_ff),
      .find_pattern   (find_pattern_ff),
      .replace_length (replace_length_ff),
      .replace_text   (replace_text_ff),
      .data_byte      (req_data_byte),
      .byte_present   (req_byte_present),
      .end_of_string  (req_end_of_string),
      .window_out     (step_window),
      .fill_out       (step_fill),
      .burst_bytes    (step_bytes),
      .burst          (step_burst)
   );

   assign last_beat = (BeatWidth'(idx_ff) + BeatWidth'(1)) == burst_ctl_ff.beats;
   assign rsp_valid = busy_ff;
   assign rsp_xfer  = busy_ff && !rsp_stall;
   // a new item may enter as the last beat of the current burst leaves
   assign req_stall = busy_ff && !(rsp_xfer && last_beat);
   assign req_xfer  = req_valid && !req_stall;

   assign rsp_out_byte    = burst_ctl_ff.marker ? 8'd0 : burst_ff[idx_ff];
   assign rsp_out_valid   = !burst_ctl_ff.marker;
   assign rsp_last_of_run = last_beat;
   assign rsp_string_done = burst_ctl_ff.done && last_beat;

   always_comb begin
      find_length_in    = find_length_ff;
      find_pattern_in   = find_pattern_ff;
      replace_length_in = replace_length_ff;
      replace_text_in   = replace_text_ff;
      window_in         = window_ff;
      fill_in           = fill_ff;
      burst_in          = burst_ff;
      burst_ctl_in      = burst_ctl_ff;
      idx_in            = idx_ff;
      busy_in           = busy_ff;

      if (rsp_xfer) begin
         if (last_beat) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IdxWidth'(1);
         end
      end

      if (req_xfer) begin
         window_in = step_window;
         fill_in   = step_fill;
         if (step_burst.beats != '0) begin
            busy_in      = 1'b1;
            idx_in       = '0;
            burst_in     = step_bytes;
            burst_ctl_in = step_burst;
         end
      end

      if (csr_write) begin
         case (csr_index)
            RegFindLength: begin
               find_length_in = csr_wdata[LenWidth-1:0];
               fill_in        = '0;
            end
            RegFindPattern:   find_pattern_in   = csr_wdata;
            RegReplaceLength: replace_length_in = csr_wdata[LenWidth-1:0];
            RegReplaceText:   replace_text_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_length_ff    <= LenWidth'(1);
         find_pattern_ff   <= '0;
         replace_length_ff <= '0;
         replace_text_ff   <= '0;
         fill_ff           <= '0;
         busy_ff           <= 1'b0;
         idx_ff            <= '0;
         burst_ctl_ff      <= '0;
      end else begin
         find_length_ff    <= find_length_in;
         find_pattern_ff   <= find_pattern_in;
         replace_length_ff <= replace_length_in;
         replace_text_ff   <= replace_text_in;
         fill_ff           <= fill_in;
         busy_ff           <= busy_in;
         idx_ff            <= idx_in;
         burst_ctl_ff      <= burst_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      burst_ff  <= burst_in;
   end

   // window never holds a complete pattern between items
   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) < MAX_FIND_LENGTH)
      else $error("window fill reached pattern capacity");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (burst_ctl_ff.beats != '0) &&
                  (BeatWidth'(idx_ff) < burst_ctl_ff.beats))
      else $error("beat index outside burst");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff && burst_ctl_ff.marker |-> burst_ctl_ff.beats == BeatWidth'(1) &&
                                         burst_ctl_ff.done)
      else $error("end marker burst malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !last_beat |=> busy_ff && (idx_ff == $past(idx_ff) + IdxWidth'(1)))
      else $error("burst did not advance after transfer");

endmodule

/* bench/stream_find_replace_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_core_test
// Self-checking bench for the stream find/replace core. A local model of the
// byte window predicts every result beat. Directed tests cover the register
// limits and the end-of-string corner cases. Random strings are built mostly
// from the pattern's own bytes so that matches, near misses and overlaps are
// frequent. Both handshakes idle at random, with one long result stall.
// ----------------------------------------------------------------------------
module stream_find_replace_core_test;
   import sfr_pkg::*;

   localparam int FindMax      = MaxFindLengthDefault;
   localparam int ReplMax      = MaxReplaceLengthDefault;
   localparam int QuietLimit   = 2000;
   localparam int RandomTarget = 500;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       has_byte;
      logic       run_end;
      logic       str_end;
   } out_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = RegFindLength;
   logic [63:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic        rsp_last_of_run;
   logic        rsp_string_done;

   // shadow of the core's registers and byte window
   logic [3:0]  cfg_find_len  = 4'd1;
   logic [63:0] cfg_pattern   = '0;
   logic [3:0]  cfg_repl_len  = 4'd0;
   logic [63:0] cfg_repl_text = '0;
   logic [7:0]  win_q [FindMax];
   int          win_fill = 0;

   out_beat_type rewrite_due [$];
   int          mismatches   = 0;
   int          items_sent   = 0;
   int          quiet_cycles = 0;
   int          rsp_wait     = 0;
   int          rsp_hold     = 0;
   bit          req_gaps     = 1'b1;
   bit          rsp_gaps     = 1'b1;
   bit          narrow       = 1'b0;

   stream_find_replace_core uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_byte_present  (req_byte_present),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_string_done   (rsp_string_done)
   );

   always #10 clock = ~clock;

   function automatic int eff_find_len();
      if (cfg_find_len == 0) return 1;
      if (cfg_find_len > FindMax) return FindMax;
      return cfg_find_len;
   endfunction

   function automatic int eff_repl_len();
      if (cfg_repl_len > ReplMax) return ReplMax;
      return cfg_repl_len;
   endfunction

   // advances the shadow window by one item and queues the beats it causes
   function automatic void rewrite_byte(input logic [7:0] b, input logic present,
                                        input logic last_item);
      out_beat_type beats [$];
      int fl;
      int rl;
      int i;
      logic hit;
      fl = eff_find_len();
      rl = eff_repl_len();
      if (present && win_fill < FindMax) begin
         win_q[win_fill] = b;
         win_fill++;
         if (win_fill >= fl) begin
            hit = 1'b1;
            for (i = 0; i < fl; i++)
               if (win_q[i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               for (i = 0; i < rl; i++)
                  beats.push_back('{cfg_repl_text[8*i +: 8], 1'b1, 1'b0, 1'b0});
               for (i = 0; i < win_fill - fl; i++) win_q[i] = win_q[i+fl];
               win_fill -= fl;
            end else begin
               beats.push_back('{win_q[0], 1'b1, 1'b0, 1'b0});
               for (i = 0; i < win_fill - 1; i++) win_q[i] = win_q[i+1];
               win_fill--;
            end
         end
      end
      if (last_item) begin
         for (i = 0; i < win_fill && beats.size() < MaxResults; i++)
            beats.push_back('{win_q[i], 1'b1, 1'b0, 1'b0});
         win_fill = 0;
         if (beats.size() == 0) beats.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
         beats[beats.size()-1].str_end = 1'b1;
      end
      if (beats.size() > 0) beats[beats.size()-1].run_end = 1'b1;
      foreach (beats[k]) rewrite_due.push_back(beats[k]);
   endfunction

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("%0t ns: %s mismatch: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // result side: compare each transfer, then draw the stall before the next one
   always @(posedge clock) begin : result_check
      out_beat_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rewrite_due.size() == 0) begin
               report("unexpected result", rsp_out_byte, 8'h00);
            end else begin
               want = rewrite_due.pop_front();
               if (rsp_out_byte !== want.byte_val)
                  report("out_byte", rsp_out_byte, want.byte_val);
               if (rsp_out_valid !== want.has_byte)
                  report("out_valid", rsp_out_valid, want.has_byte);
               if (rsp_last_of_run !== want.run_end)
                  report("last_of_run", rsp_last_of_run, want.run_end);
               if (rsp_string_done !== want.str_end)
                  report("string_done", rsp_string_done, want.str_end);
            end
            rsp_wait = rsp_gaps ? $urandom_range(0, 10) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t ns: no transfer for %0d cycles", $realtime, QuietLimit);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // valid stays high after a transfer; the next call or drain() decides
   task automatic send_item(input logic [7:0] b, input logic present, input logic last_item);
      int gap;
      gap = req_gaps ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_byte_present  <= present;
      req_end_of_string <= last_item;
      do @(posedge clock); while (req_stall !== 1'b0);
      rewrite_byte(b, present, last_item);
      if (present || last_item) items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (rewrite_due.size() != 0) @(posedge clock);
      // items that cause no result may still be in flight
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_write high; callers lower it after their last write
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         RegFindLength: begin
            cfg_find_len = value[3:0];
            win_fill     = 0;
         end
         RegFindPattern:   cfg_pattern   = value;
         RegReplaceLength: cfg_repl_len  = value[3:0];
         RegReplaceText:   cfg_repl_text = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [3:0] find_len, input logic [63:0] pattern,
                            input logic [3:0] repl_len, input logic [63:0] repl_text);
      logic [63:0] len_word;
      len_word      = {$urandom, $urandom};
      len_word[3:0] = find_len;
      write_reg(RegFindLength, len_word);
      write_reg(RegFindPattern, pattern);
      len_word      = {$urandom, $urandom};
      len_word[3:0] = repl_len;
      write_reg(RegReplaceLength, len_word);
      write_reg(RegReplaceText, repl_text);
      csr_write <= 1'b0;
   endtask

   task automatic set_find_length(input logic [3:0] find_len);
      write_reg(RegFindLength, {60'd0, find_len});
      csr_write <= 1'b0;
   endtask

   function automatic logic [3:0] pick_len(input int lo, input int hi);
      if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(lo, hi));
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0, 1:    return cfg_pattern[8*$urandom_range(0, eff_find_len()-1) +: 8];
         2:       return narrow ? 8'h61 : 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // defaults after reset: find length 1, pattern zero, empty replacement
   task automatic test_reset_state();
      send_item(8'h00, 1'b1, 1'b0);   // zero byte matches, deleted, no result
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h80, 1'b0, 1'b0);   // neither byte nor end: ignored
      send_item(8'h01, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);   // end with nothing pending gives a marker
      drain();
   endtask

   task automatic test_basic_replace();
      configure(4'd2, 64'h6261, 4'd3, 64'h5A5958);   // "ab" -> "XYZ"
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b1);   // match on the closing transfer
      drain();
   endtask

   task automatic test_length_limits();
      int i;
      // out-of-range lengths clamp to eight bytes
      configure(4'd15, '1, 4'd15, 64'h8877_6655_4433_2211);
      for (i = 0; i < 8; i++) send_item(8'hFF, 1'b1, i == 7);
      drain();
      // zero find length acts as one; zero replacement deletes
      configure(4'd0, 64'hFFFF_FFFF_FFFF_FF41, 4'd0, '1);
      send_item(8'h42, 1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b1);
      drain();
   endtask

   task automatic test_pattern_rewrite();
      configure(4'd4, 64'h6463_6261, 4'd1, 64'h2A);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      drain();
      set_find_length(4'd4);          // pending bytes are dropped
      send_item(8'h64, 1'b0, 1'b1);
      drain();
   endtask

   task automatic test_backpressure();
      int i;
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      configure(4'd1, 64'h78, 4'd8, {$urandom, $urandom});
      rsp_hold = 300;
      for (i = 0; i < 30; i++) send_item(8'h78, 1'b1, i == 29);
      drain();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      for (i = 0; i < 6; i++) send_item(8'($urandom_range(0, 255)), 1'b1, i == 5);
      drain();
   endtask

   task automatic send_string();
      int len;
      int n;
      int k;
      int fl;
      fl  = eff_find_len();
      len = $urandom_range(0, 16);
      n   = 0;
      while (n < len) begin
         if ($urandom_range(0, 2) == 0) begin
            // whole pattern or a prefix of it
            k = $urandom_range(0, 1) ? fl : $urandom_range(1, fl);
            for (int j = 0; j < k; j++) send_item(cfg_pattern[8*j +: 8], 1'b1, 1'b0);
            n += k;
         end else begin
            send_item(pick_byte(), 1'b1, 1'b0);
            n++;
         end
         if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      case ($urandom_range(0, 7))
         0: begin
            // string left open; sometimes the window is dropped by a length rewrite
            if ($urandom_range(0, 1)) begin
               drain();
               set_find_length(pick_len(1, 3));
            end
         end
         1, 2:    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         default: send_item(pick_byte(), 1'b1, 1'b1);
      endcase
   endtask

   task automatic test_random_strings();
      logic [63:0] pattern;
      int strings;
      while (items_sent < RandomTarget) begin
         drain();
         req_gaps = $urandom_range(0, 2) != 0;
         rsp_gaps = $urandom_range(0, 2) != 0;
         narrow   = 1'($urandom_range(0, 1));
         pattern  = {$urandom, $urandom};
         if (narrow)
            for (int j = 0; j < 8; j++) pattern[8*j +: 8] = 8'h61 + 8'($urandom_range(0, 1));
         configure(pick_len(1, 3), pattern, pick_len(0, 3), {$urandom, $urandom});
         strings = $urandom_range(1, 6);
         for (int s = 0; s < strings; s++) begin
            send_string();
            if ($urandom_range(0, 4) == 0) drain();   // sender waits for all results
         end
      end
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_basic_replace();
      test_length_limits();
      test_pattern_rewrite();
      test_backpressure();
      test_random_strings();
      if (mismatches == 0 && rewrite_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
